// ===== rtl/inode_table_reference_counter_assert.svh =====
// assertion macros for the inode table reference counter checker
// depends on nothing; expects a clock named clk and an active-low reset named rst_n in scope
`ifndef INODE_TABLE_REFERENCE_COUNTER_ASSERT_SVH
`define INODE_TABLE_REFERENCE_COUNTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ITB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ITB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/itb_pkg.sv =====
// shared types and constants of the inode table reference counter
// used by the slot cells, the locate pipeline, the top level and the checker
`default_nettype none

package itb_pkg;

  localparam int unsigned INO_W  = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BLK_W  = 16;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned SIDX_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // request codes
  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_FULL      = 3'd2,
    ST_STILL     = 3'd3,
    ST_WRITEBACK = 3'd4,
    ST_IGNORED   = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_UPD,
    S_LOC1,
    S_LOC2,
    S_LOC3
  } fsm_t;

  // phase broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_SEL,
    CELL_UPD
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    req_t              req;
    logic              use_free;
    logic [INO_W-1:0]  ino;
    logic [SIDX_W-1:0] slot;
  } cell_cmd_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic             hit;
    logic             free;
    logic [CNT_W-1:0] cnt;
    logic [INO_W-1:0] ino;
  } link_t;

endpackage

`default_nettype wire

// ===== rtl/itb_cell.sv =====
// one slot of the open-inode table: count, inode number and priority link
// depends on itb_pkg
`default_nettype none

module itb_cell
  import itb_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  cell_cmd_t  cmd,
  input  link_t      link_i,
  output link_t      link_o,
  output logic       sel_o
);

  localparam bit                IDX_OK = (CELL_IDX < (1 << SIDX_W));
  localparam logic [SIDX_W-1:0] IDX_LO = SIDX_W'(CELL_IDX);

  logic [CNT_W-1:0] cnt_r;
  logic [INO_W-1:0] ino_r;
  logic             hit_r;
  logic             free_r;
  logic             hgnt_r;
  logic             fgnt_r;
  logic             live;
  logic             slot_hit;

  assign live     = (cnt_r != '0);
  assign slot_hit = IDX_OK && (cmd.slot == IDX_LO);
  assign sel_o    = hgnt_r | (cmd.use_free & fgnt_r);

  // chain: flags collect lower cells, selected data rides along
  always_comb begin
    link_o.hit  = link_i.hit | hit_r;
    link_o.free = link_i.free | free_r;
    link_o.cnt  = link_i.cnt | (sel_o ? cnt_r : '0);
    link_o.ino  = link_i.ino | (sel_o ? ino_r : '0);
  end

  // compare and grant flags
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_CMP: begin
        free_r <= !live;
        case (cmd.req)
          REQ_GET: hit_r <= live && (ino_r == cmd.ino);
          REQ_PUT: hit_r <= live && slot_hit;
          default: hit_r <= 1'b0;
        endcase
      end
      CELL_SEL: begin
        hgnt_r <= hit_r & ~link_i.hit;
        fgnt_r <= free_r & ~link_i.free;
      end
      default: ;
    endcase
  end

  // slot update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.op == CELL_UPD) begin
      case (cmd.req)
        REQ_GET: begin
          if (hgnt_r) begin
            if (cnt_r != CNT_MAX) cnt_r <= cnt_r + CNT_W'(1);
          end else if (cmd.use_free && fgnt_r) begin
            cnt_r <= CNT_W'(1);
          end
        end
        REQ_PUT: begin
          if (hgnt_r) cnt_r <= cnt_r - CNT_W'(1);
        end
        REQ_CLEAR: cnt_r <= '0;
        default: ;
      endcase
    end
  end

  // inode number written on a claim only
  always_ff @(posedge clk) begin
    if (cmd.op == CELL_UPD && cmd.req == REQ_GET && cmd.use_free && fgnt_r) begin
      ino_r <= cmd.ino;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itb_locate.sv =====
// inode to disk block and byte offset, free-running pipeline
// depends on itb_pkg
`default_nettype none

module itb_locate
  import itb_pkg::*;
#(
  parameter int unsigned INODES_IN_BLOCK = 64,
  parameter int unsigned INODE_BYTES     = 64
) (
  input  wire              clk,
  input  wire [INO_W-1:0]  ino,
  input  wire [BLK_W-1:0]  area_start,
  output logic [BLK_W-1:0] blk,
  output logic [OFS_W-1:0] ofs
);

  // ceil(2^32 / INODES_IN_BLOCK): exact quotient for any 16-bit inode
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(INODES_IN_BLOCK) - 64'd1) / 64'(INODES_IN_BLOCK);
  localparam logic [32:0]     RECIP   = 33'(RECIP_L);
  localparam int unsigned     PROD_W  = INO_W + 33;
  localparam int unsigned     QD_W    = INO_W + 9;
  localparam int unsigned     REM_W   = 8;
  localparam int unsigned     OP_W    = REM_W + 9;

  logic [PROD_W-1:0] prod;
  logic [INO_W-1:0]  q_r;
  logic [INO_W-1:0]  n_r;
  logic [QD_W-1:0]   qd;
  logic [REM_W-1:0]  rem_r;
  logic [BLK_W-1:0]  blk_r;
  logic [OP_W-1:0]   ofs_full;

  // stage one: quotient by reciprocal multiply
  assign prod = PROD_W'(ino) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= prod[32 +: INO_W];
    n_r <= ino;
  end

  // stage two: remainder and block number
  assign qd = QD_W'(q_r) * QD_W'(INODES_IN_BLOCK);

  always_ff @(posedge clk) begin
    rem_r <= REM_W'(n_r - INO_W'(qd));
    blk_r <= BLK_W'(q_r + area_start);
  end

  // stage three: byte offset inside the block
  assign ofs_full = OP_W'(rem_r) * OP_W'(INODE_BYTES);
  assign ofs      = ofs_full[OFS_W-1:0];
  assign blk      = blk_r;

endmodule

`default_nettype wire

// ===== rtl/inode_table_reference_counter.sv =====
// top level of the inode table reference counter: sequencer, slot cell chain, locate pipeline
// depends on itb_pkg, itb_cell and itb_locate
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------------
//  request  | start, busy               | in_req_type, in_inode_number, in_slot_index
//  result   | out_valid (strobe)        | out_status, out_slot_used, out_slot_inode,
//           |                           | out_disk_block, out_byte_offset, out_count_after
//  config   | cfg_valid, cfg_ready      | cfg_inode_area_start
//
// an item is taken when start is high and busy low; busy then stays high through the
// compare, priority grant along the cell chain, update and three locate stages, and the
// result strobe rises as busy falls, when the next item may already be taken
// rst_n is synchronous; it frees every slot and zeroes the inode area start
// the result strobe lasts one cycle and cannot be held off
`default_nettype none

module inode_table_reference_counter
  import itb_pkg::*;
#(
  parameter int unsigned SLOT_COUNT      = 16,
  parameter int unsigned INODES_IN_BLOCK = 64,
  parameter int unsigned INODE_BYTES     = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [1:0]          in_req_type,
  input  wire [INO_W-1:0]    in_inode_number,
  input  wire [SIDX_W-1:0]   in_slot_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [SIDX_W-1:0]  out_slot_used,
  output logic [INO_W-1:0]   out_slot_inode,
  output logic [BLK_W-1:0]   out_disk_block,
  output logic [OFS_W-1:0]   out_byte_offset,
  output logic [CNT_W-1:0]   out_count_after,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [BLK_W-1:0]    cfg_inode_area_start
);

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  fsm_t              state_r, state_nxt;
  logic              accept;
  logic              out_valid_r;
  logic [BLK_W-1:0]  area_start_r;

  req_t              req_r;
  logic [INO_W-1:0]  ino_r;
  logic [SIDX_W-1:0] slot_r;
  logic              any_hit_r;
  logic              any_free_r;

  cell_cmd_t         cmd;
  link_t             link [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] sel;
  logic [SLOT_W-1:0] sel_idx;

  status_t           res_status;
  logic [SIDX_W-1:0] res_slot;
  logic [INO_W-1:0]  res_ino;
  logic [CNT_W-1:0]  res_cnt;
  logic              res_loc;
  logic [CNT_W-1:0]  old_cnt;

  status_t           status_r;
  logic [SIDX_W-1:0] slot_used_r;
  logic [INO_W-1:0]  slot_ino_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              loc_r;

  logic [BLK_W-1:0]  loc_blk;
  logic [OFS_W-1:0]  loc_ofs;
  logic [BLK_W-1:0]  blk_out_r;
  logic [OFS_W-1:0]  ofs_out_r;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SEL;
      S_SEL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_LOC1;
      S_LOC1: state_nxt = S_LOC2;
      S_LOC2: state_nxt = S_LOC3;
      S_LOC3: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: busy and the phase sent to the cells
  always_comb begin
    busy         = 1'b1;
    cmd.op       = CELL_HOLD;
    cmd.req      = req_r;
    cmd.ino      = ino_r;
    cmd.slot     = slot_r;
    cmd.use_free = (req_r == REQ_GET) & ~any_hit_r;
    unique case (state_r)
      S_IDLE:  busy   = 1'b0;
      S_CMP:   cmd.op = CELL_CMP;
      S_SEL:   cmd.op = CELL_SEL;
      S_UPD:   cmd.op = CELL_UPD;
      default: cmd.op = CELL_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      area_start_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_LOC3);
      if (cfg_valid && cfg_ready) area_start_r <= cfg_inode_area_start;
    end
  end

  // request capture and chain summary
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= req_t'(in_req_type);
      ino_r  <= in_inode_number;
      slot_r <= in_slot_index;
    end
    if (state_r == S_SEL) begin
      any_hit_r  <= link[SLOT_COUNT].hit;
      any_free_r <= link[SLOT_COUNT].free;
    end
  end

  // row of slot cells
  assign link[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    itb_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .sel_o  (sel[i])
    );
  end

  // number of the selected cell
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (sel[i]) sel_idx = sel_idx | SLOT_W'(i);
    end
  end

  // result of the request from the gathered slot data
  assign old_cnt = link[SLOT_COUNT].cnt;

  always_comb begin
    res_status = ST_IGNORED;
    res_slot   = '0;
    res_ino    = '0;
    res_cnt    = '0;
    res_loc    = 1'b0;
    case (req_r)
      REQ_GET: begin
        res_ino = ino_r;
        if (any_hit_r) begin
          res_status = ST_HIT;
          res_slot   = SIDX_W'(sel_idx);
          res_cnt    = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + CNT_W'(1);
        end else if (any_free_r) begin
          res_status = ST_MISS;
          res_slot   = SIDX_W'(sel_idx);
          res_cnt    = CNT_W'(1);
          res_loc    = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      REQ_PUT: begin
        res_slot = slot_r;
        if (any_hit_r) begin
          res_ino = link[SLOT_COUNT].ino;
          res_cnt = old_cnt - CNT_W'(1);
          if (old_cnt == CNT_W'(1)) begin
            res_status = ST_WRITEBACK;
            res_loc    = 1'b1;
          end else begin
            res_status = ST_STILL;
          end
        end
      end
      REQ_CLEAR: res_status = ST_CLEARED;
      default:   res_status = ST_IGNORED;
    endcase
  end

  // result held while the locate pipeline runs
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      status_r    <= res_status;
      slot_used_r <= res_slot;
      slot_ino_r  <= res_ino;
      cnt_r       <= res_cnt;
      loc_r       <= res_loc;
    end
    if (state_r == S_LOC3) begin
      blk_out_r <= loc_r ? loc_blk : '0;
      ofs_out_r <= loc_r ? loc_ofs : '0;
    end
  end

  itb_locate #(
    .INODES_IN_BLOCK (INODES_IN_BLOCK),
    .INODE_BYTES     (INODE_BYTES)
  ) u_locate (
    .clk        (clk),
    .ino        (slot_ino_r),
    .area_start (area_start_r),
    .blk        (loc_blk),
    .ofs        (loc_ofs)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_used   = slot_used_r;
  assign out_slot_inode  = slot_ino_r;
  assign out_disk_block  = blk_out_r;
  assign out_byte_offset = ofs_out_r;
  assign out_count_after = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/itb_checker.sv =====
// port-level checks on the inode table reference counter, bound to the top level
// depends on itb_pkg and inode_table_reference_counter_assert.svh
`default_nettype none
`include "inode_table_reference_counter_assert.svh"

module itb_checker
  import itb_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire       out_valid,
  input wire [2:0] out_status,
  input wire [3:0] out_slot_used,
  input wire [7:0] out_count_after
);

  // a taken item keeps the block busy in the next cycle
  `ITB_ASSERT_NEXT(a_take_busy, start && !busy, busy, "item taken but block not busy")

  // one strobe per item
  `ITB_ASSERT_NEXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than one cycle")

  // the block is free again when its result shows
  `ITB_ASSERT_NOW(a_free_at_result, out_valid, !busy, "block still busy with result shown")

  // a claimed slot starts with one reference
  `ITB_ASSERT_NOW(a_miss_count, out_valid && out_status == ST_MISS, out_count_after == 8'd1,
    "miss result without count of one")

  // a full table reports no slot and no count
  `ITB_ASSERT_NOW(a_full_fields, out_valid && out_status == ST_FULL,
    out_slot_used == 4'd0 && out_count_after == 8'd0, "full result with slot or count set")

endmodule

bind inode_table_reference_counter itb_checker u_itb_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the inode table reference counter
// depends on itb_pkg and the inode_table_reference_counter top level in rtl/
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import itb_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned GROUP_INODES = 64;
  localparam int unsigned INODE_STRIDE = 64;

  typedef struct packed {
    status_t           status;
    logic [SIDX_W-1:0] slot;
    logic [INO_W-1:0]  ino;
    logic [BLK_W-1:0]  blk;
    logic [OFS_W-1:0]  ofs;
    logic [CNT_W-1:0]  cnt;
  } inode_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [1:0]        in_req_type = '0;
  logic [INO_W-1:0]  in_inode_number = '0;
  logic [SIDX_W-1:0] in_slot_index = '0;
  logic              cfg_valid = 1'b0;
  logic [BLK_W-1:0]  cfg_inode_area_start = '0;

  wire               busy;
  wire               out_valid;
  wire [2:0]         out_status;
  wire [SIDX_W-1:0]  out_slot_used;
  wire [INO_W-1:0]   out_slot_inode;
  wire [BLK_W-1:0]   out_disk_block;
  wire [OFS_W-1:0]   out_byte_offset;
  wire [CNT_W-1:0]   out_count_after;
  wire               cfg_ready;

  // shadow copy of the slot table and the area register
  logic [CNT_W-1:0] slot_refs [SLOTS];
  logic [INO_W-1:0] slot_inodes [SLOTS];
  logic [BLK_W-1:0] area_start;

  inode_reply_t pending_replies[$];
  int unsigned  mismatches = 0;
  bit           gaps_on = 1'b1;

  inode_table_reference_counter i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_inode_number      (in_inode_number),
    .in_slot_index        (in_slot_index),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slot_used        (out_slot_used),
    .out_slot_inode       (out_slot_inode),
    .out_disk_block       (out_disk_block),
    .out_byte_offset      (out_byte_offset),
    .out_count_after      (out_count_after),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_inode_area_start (cfg_inode_area_start)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // disk position of an inode
  function automatic void locate_inode(input logic [INO_W-1:0] ino,
                                       output logic [BLK_W-1:0] blk,
                                       output logic [OFS_W-1:0] ofs);
    int unsigned blk_sum;
    int unsigned ofs_full;
    blk_sum  = ino / GROUP_INODES + area_start;
    ofs_full = (ino % GROUP_INODES) * INODE_STRIDE;
    blk = blk_sum[BLK_W-1:0];
    ofs = ofs_full[OFS_W-1:0];
  endfunction

  // applies one request to the shadow table and returns the reply it gives
  function automatic inode_reply_t apply_request(input req_t req,
                                                 input logic [INO_W-1:0] ino,
                                                 input logic [SIDX_W-1:0] sidx);
    inode_reply_t r;
    int hit_slot;
    int free_slot;
    r = '0;
    r.status = ST_IGNORED;
    hit_slot = -1;
    free_slot = -1;
    case (req)
      REQ_GET: begin
        r.ino = ino;
        for (int i = 0; i < SLOTS; i++)
          if (hit_slot < 0 && slot_refs[i] != 0 && slot_inodes[i] == ino) hit_slot = i;
        if (hit_slot >= 0) begin
          // count saturates at its maximum
          if (slot_refs[hit_slot] != CNT_MAX) slot_refs[hit_slot]++;
          r.status = ST_HIT;
          r.slot = hit_slot[SIDX_W-1:0];
          r.cnt = slot_refs[hit_slot];
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && slot_refs[i] == 0) free_slot = i;
          if (free_slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_refs[free_slot] = CNT_W'(1);
            slot_inodes[free_slot] = ino;
            r.status = ST_MISS;
            r.slot = free_slot[SIDX_W-1:0];
            locate_inode(ino, r.blk, r.ofs);
            r.cnt = CNT_W'(1);
          end
        end
      end
      REQ_PUT: begin
        r.slot = sidx;
        if (slot_refs[sidx] != 0) begin
          slot_refs[sidx]--;
          r.ino = slot_inodes[sidx];
          r.cnt = slot_refs[sidx];
          if (r.cnt == 0) begin
            r.status = ST_WRITEBACK;
            locate_inode(r.ino, r.blk, r.ofs);
          end else begin
            r.status = ST_STILL;
          end
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_refs[i] = '0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    return r;
  endfunction

  // sends one item and records its expected reply once taken
  task automatic send_request(input req_t req, input logic [INO_W-1:0] ino,
                              input logic [SIDX_W-1:0] sidx);
    start <= 1'b1;
    in_req_type <= req;
    in_inode_number <= ino;
    in_slot_index <= sidx;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    pending_replies.push_back(apply_request(req, ino, sidx));
  endtask

  // random gap on the request side, counted from when the block could take an item
  task automatic maybe_pause();
    if (gaps_on && $urandom_range(99) < 31) begin
      start <= 1'b0;
      do @(negedge clk); while (busy !== 1'b0);
      @(posedge clk);
      while ($urandom_range(99) < 31) @(posedge clk);
    end
  endtask

  // hold requests until every reply is back, then let the pipeline settle
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // write the inode area start while the block is idle
  task automatic set_area_start(input logic [BLK_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_inode_area_start <= value;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    cfg_valid <= 1'b0;
    area_start = value;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // reply checker, sampled mid-cycle while the strobe is stable
  always @(negedge clk) begin
    inode_reply_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual status %0d slot %0d",
                 $time, out_status, out_slot_used);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("slot_used", 32'(want.slot), 32'(out_slot_used));
        check_field("slot_inode", 32'(want.ino), 32'(out_slot_inode));
        check_field("disk_block", 32'(want.blk), 32'(out_disk_block));
        check_field("byte_offset", 32'(want.ofs), 32'(out_byte_offset));
        check_field("count_after", 32'(want.cnt), 32'(out_count_after));
      end
    end
  end

  // puts on free slots, the unused request code and a clear on an empty table
  task automatic test_after_reset();
    send_request(REQ_PUT, 16'h0000, 4'h0);
    send_request(REQ_PUT, 16'hFFFF, 4'hF);
    send_request(REQ_NONE, 16'hFFFF, 4'hF);
    send_request(REQ_CLEAR, 16'h0000, 4'h0);
  endtask

  // miss, hit, still referenced, writeback and ignored put
  task automatic test_get_put();
    send_request(REQ_GET, 16'h0000, 4'h0);
    send_request(REQ_GET, 16'hFFFF, 4'h0);
    send_request(REQ_GET, 16'h0000, 4'hF);
    send_request(REQ_PUT, 16'h0000, 4'h0);
    send_request(REQ_PUT, 16'h0000, 4'h0);
    send_request(REQ_PUT, 16'h0000, 4'h0);
    send_request(REQ_PUT, 16'h0000, 4'h1);
  endtask

  // block number wraps at the top of the area start range
  task automatic test_area_extremes();
    set_area_start(16'hFFFF);
    send_request(REQ_GET, 16'hFFFF, 4'h0);
    send_request(REQ_GET, 16'h003F, 4'h0);
    send_request(REQ_PUT, 16'h0000, 4'h0);
    send_request(REQ_PUT, 16'h0000, 4'h1);
    set_area_start(16'h0000);
  endtask

  // fill every slot with distinct inodes, overflow, then reuse the freed slot
  task automatic test_table_full();
    logic [INO_W-1:0] base;
    logic [SIDX_W-1:0] victim;
    base = INO_W'($urandom_range(0, 65535));
    victim = SIDX_W'($urandom_range(0, SLOTS - 1));
    send_request(REQ_CLEAR, base, 4'h0);
    for (int i = 0; i < SLOTS; i++) begin
      send_request(REQ_GET, base ^ INO_W'(i), SIDX_W'($urandom_range(0, 15)));
      maybe_pause();
    end
    send_request(REQ_GET, base ^ INO_W'(SLOTS), 4'h0);
    send_request(REQ_GET, base ^ INO_W'(3), 4'h0);
    send_request(REQ_PUT, base, 4'h3);
    send_request(REQ_PUT, base, victim);
    send_request(REQ_GET, base ^ INO_W'(SLOTS + 1), 4'h0);
    send_request(REQ_CLEAR, base, 4'h0);
  endtask

  // drive one slot's count past its maximum and back down
  task automatic test_count_saturation();
    logic [INO_W-1:0] ino;
    ino = INO_W'($urandom_range(0, 65535));
    send_request(REQ_CLEAR, ino, 4'h0);
    for (int i = 0; i < 258; i++) begin
      send_request(REQ_GET, ino, SIDX_W'($urandom_range(0, 15)));
      maybe_pause();
    end
    send_request(REQ_PUT, ino, 4'h0);
    send_request(REQ_PUT, ino, 4'h0);
    send_request(REQ_CLEAR, ino, 4'h0);
  endtask

  // mixed traffic over a small inode pool so hits, misses and full tables all occur
  task automatic test_random_traffic(input int n, input logic [BLK_W-1:0] area,
                                     input bit drain_midway);
    logic [INO_W-1:0] pool [20];
    int live_slots[$];
    int r;
    logic [INO_W-1:0] ino;
    logic [SIDX_W-1:0] sidx;
    set_area_start(area);
    foreach (pool[j]) pool[j] = INO_W'($urandom_range(0, 65535));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      ino = INO_W'($urandom_range(0, 65535));
      sidx = SIDX_W'($urandom_range(0, 15));
      if (r < 48) begin
        if ($urandom_range(9) != 0) ino = pool[$urandom_range(0, 19)];
        send_request(REQ_GET, ino, sidx);
      end else if (r < 90) begin
        live_slots.delete();
        for (int i = 0; i < SLOTS; i++) if (slot_refs[i] != 0) live_slots.push_back(i);
        if (live_slots.size() != 0 && $urandom_range(4) != 0)
          sidx = SIDX_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        send_request(REQ_PUT, ino, sidx);
      end else if (r < 93) begin
        send_request(REQ_CLEAR, ino, sidx);
      end else begin
        send_request(REQ_NONE, ino, sidx);
      end
      // halfway through, if asked, hold off until the block has answered everything; else maybe pause
      if (drain_midway && k == n / 2) wait_drained();
      else maybe_pause();
    end
  endtask

  // run-time limit
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_refs[i] = '0;
      slot_inodes[i] = '0;
    end
    area_start = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_get_put();
    test_area_extremes();
    test_table_full();
    test_count_saturation();
    test_random_traffic(250, 16'hFFFF, 1'b1);
    gaps_on = 1'b0;
    test_random_traffic(200, BLK_W'($urandom_range(0, 65535)), 1'b0);
    gaps_on = 1'b1;
    test_random_traffic(200, 16'h8000, 1'b0);
    test_random_traffic(200, 16'h0000, 1'b0);

    wait_drained();
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
